@@ design/iim_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iim_pkg
// Shared types and constants for the interval insert and merge block.
// ----------------------------------------------------------------------------
package iim_pkg;

    localparam int DATA_W        = 32;
    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // One classified command handed from the front to the back.
    typedef struct packed {
        logic                     is_insert;
        logic signed [DATA_W-1:0] range_start;
        logic signed [DATA_W-1:0] range_end;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } back_state_t;

    // Where the table walk stands relative to the new interval.
    typedef enum logic [1:0] {
        PH_BEFORE,
        PH_MERGE,
        PH_AFTER
    } walk_phase_t;

endpackage
`default_nettype wire

@@ design/iim_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iim_front
// Accepts input transactions, classifies them and queues them in a
// two-entry buffer for the back end.
// ----------------------------------------------------------------------------
module iim_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    input  wire logic [63:0]          s_axis_tdata,   // [31:0] range_start, [63:32] range_end
    input  wire logic                 s_axis_tuser,   // [0] opcode
    output      logic                 cmd_valid,
    input  wire logic                 cmd_ready,
    output      iim_pkg::cmd_t        cmd
);

    logic [1:0]    count_reg, count_next;
    iim_pkg::cmd_t slot0_reg, slot0_next;
    iim_pkg::cmd_t slot1_reg, slot1_next;
    iim_pkg::cmd_t in_cmd;
    logic          push;
    logic          pop;
    logic [1:0]    wr_pos;

    always_comb begin
        in_cmd.is_insert   = (s_axis_tuser == iim_pkg::OP_INSERT);
        in_cmd.range_start = $signed(s_axis_tdata[31:0]);
        in_cmd.range_end   = $signed(s_axis_tdata[63:32]);
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign cmd_valid     = (count_reg != 2'd0);
    assign cmd           = slot0_reg;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = cmd_ready && cmd_valid;
    assign wr_pos        = count_reg - {1'b0, pop};

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        if (pop) begin
            slot0_next = slot1_reg;
        end
        if (push) begin
            if (wr_pos == 2'd0) begin
                slot0_next = in_cmd;
            end else begin
                slot1_next = in_cmd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule
`default_nettype wire

@@ design/iim_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iim_back
// Holds the interval table, executes loads and walks the table on an
// insert, emitting the merged list through an output register.
// ----------------------------------------------------------------------------
module iim_back #(
    parameter int TABLE_DEPTH = iim_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output      logic          cmd_ready,
    input  wire iim_pkg::cmd_t cmd,
    output      logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output      logic [63:0]   m_axis_tdata,   // [31:0] merged_start, [63:32] merged_end
    output      logic          m_axis_tlast,   // last_of_run
    output      logic          m_axis_tuser    // [0] overflowed
);

    localparam int DW    = iim_pkg::DATA_W;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic signed [DW-1:0] mem_start [TABLE_DEPTH];
    logic signed [DW-1:0] mem_end   [TABLE_DEPTH];

    iim_pkg::back_state_t state_reg, state_next;
    iim_pkg::walk_phase_t phase_reg, phase_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 dropped_reg, dropped_next;
    logic signed [DW-1:0] s_reg, s_next;
    logic signed [DW-1:0] e_reg, e_next;
    logic signed [DW-1:0] rd_start_reg, rd_end_reg;
    logic [IDX_W-1:0]     rd_addr;

    logic                 wr_en;
    logic                 can_emit;
    logic                 emit;
    logic signed [DW-1:0] emit_start, emit_end;
    logic                 emit_last, emit_ovf;
    logic                 last_entry;

    logic                 out_valid_reg;
    logic signed [DW-1:0] out_start_reg, out_end_reg;
    logic                 out_last_reg, out_ovf_reg;

    assign can_emit   = !out_valid_reg || m_axis_tready;
    assign last_entry = ((idx_reg + CNT_W'(1)) == count_reg);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        dropped_next = dropped_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        cmd_ready    = 1'b0;
        wr_en        = 1'b0;
        emit         = 1'b0;
        emit_start   = s_reg;
        emit_end     = e_reg;
        emit_last    = 1'b0;
        emit_ovf     = 1'b0;

        unique case (state_reg)
            iim_pkg::ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_ready = 1'b1;
                    if (!cmd.is_insert) begin
                        if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            dropped_next = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else begin
                        s_next     = cmd.range_start;
                        e_next     = cmd.range_end;
                        idx_next   = '0;
                        phase_next = iim_pkg::PH_BEFORE;
                        state_next = iim_pkg::ST_WALK;
                    end
                end
            end
            iim_pkg::ST_WALK: begin
                if (can_emit) begin
                    if (idx_reg == count_reg) begin
                        // Table exhausted: the merged interval closes the list.
                        emit         = 1'b1;
                        emit_last    = 1'b1;
                        emit_ovf     = dropped_reg;
                        state_next   = iim_pkg::ST_IDLE;
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end else begin
                        unique case (phase_reg) inside
                            iim_pkg::PH_BEFORE, iim_pkg::PH_MERGE: begin
                                if (phase_reg == iim_pkg::PH_BEFORE && rd_end_reg < s_reg) begin
                                    emit       = 1'b1;
                                    emit_start = rd_start_reg;
                                    emit_end   = rd_end_reg;
                                    idx_next   = idx_reg + CNT_W'(1);
                                end else if (rd_start_reg <= e_reg) begin
                                    if (rd_start_reg < s_reg) begin
                                        s_next = rd_start_reg;
                                    end
                                    if (rd_end_reg > e_reg) begin
                                        e_next = rd_end_reg;
                                    end
                                    phase_next = iim_pkg::PH_MERGE;
                                    idx_next   = idx_reg + CNT_W'(1);
                                end else begin
                                    // Merged interval goes out; this entry is held and emitted in the after phase.
                                    emit       = 1'b1;
                                    phase_next = iim_pkg::PH_AFTER;
                                end
                            end
                            default: begin
                                emit       = 1'b1;
                                emit_start = rd_start_reg;
                                emit_end   = rd_end_reg;
                                emit_last  = last_entry;
                                emit_ovf   = last_entry && dropped_reg;
                                idx_next   = idx_reg + CNT_W'(1);
                                if (last_entry) begin
                                    state_next   = iim_pkg::ST_IDLE;
                                    count_next   = '0;
                                    dropped_next = 1'b0;
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
                state_next = iim_pkg::ST_IDLE;
            end
        endcase
    end

    // The read address follows the next walk index so the registered read data
    // lines up with the index register.
    always_comb begin
        if (idx_next < CNT_W'(TABLE_DEPTH)) begin
            rd_addr = idx_next[IDX_W-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_start[count_reg[IDX_W-1:0]] <= cmd.range_start;
            mem_end[count_reg[IDX_W-1:0]]   <= cmd.range_end;
        end
        rd_start_reg <= mem_start[rd_addr];
        rd_end_reg   <= mem_end[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= iim_pkg::ST_IDLE;
            phase_reg     <= iim_pkg::PH_BEFORE;
            count_reg     <= '0;
            idx_reg       <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            dropped_reg <= dropped_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s_reg <= s_next;
        e_reg <= e_next;
        if (emit) begin
            out_start_reg <= emit_start;
            out_end_reg   <= emit_end;
            out_last_reg  <= emit_last;
            out_ovf_reg   <= emit_ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_end_reg, out_start_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule
`default_nettype wire

@@ design/interval_insert_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// interval_insert_merge
// Stores closed intervals and, on an insert, emits the merged sorted list.
// ----------------------------------------------------------------------------
// Usage: the s_axis channel carries commands. tuser selects the opcode: a
// load appends [start, end] from tdata to the table, an insert merges the
// interval in tdata with every stored interval it overlaps or touches. The
// m_axis channel returns the merged list, one interval per transaction;
// tlast marks the final one, and tuser on it is set when loads were dropped
// because the table was full. The table is empty again after each insert.
// Each load completes in the idle state and produces no output. An insert
// occupies the back end for a start step, one step per table entry, read
// one entry a cycle from the table memory while the receiver does not
// stall, plus one step for the merged interval. With the back end idle, the
// first result leaves the output register after the start step and after
// each stored entry absorbed before it goes out. A two-entry
// command queue in front keeps accepting while the back end is busy until
// it fills. When the receiver stalls, the output register holds its
// transaction and the walk pauses. Reset empties the queue and the table
// and clears the dropped flag; no output is pending after reset.
// ----------------------------------------------------------------------------
module interval_insert_merge #(
    parameter int TABLE_DEPTH = iim_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] range_start, [63:32] range_end
    input  wire logic        s_axis_tuser,   // [0] opcode
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [63:0] m_axis_tdata,   // [31:0] merged_start, [63:32] merged_end
    output      logic        m_axis_tlast,   // last_of_run
    output      logic        m_axis_tuser    // [0] overflowed
);

    logic          cmd_valid;
    logic          cmd_ready;
    iim_pkg::cmd_t cmd;

    iim_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    iim_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

@@ design/iim_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iim_checker
// Port-level checks for the interval insert and merge block.
// ----------------------------------------------------------------------------
module iim_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its contents.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tdata, m_axis_tlast, m_axis_tuser}))
        else $error("result changed while stalled");

    // Reset leaves no pending result.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // The overflow flag is only reported on the final interval of a list.
    a_ovf_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("overflow flag on a non-final result");

    // The command queue is empty and ready right after reset.
    a_ready_after_reset: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind interval_insert_merge iim_checker u_iim_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
